/* rtl/ldpm_pkg.sv */
// Shared widths, constants and types for the lens distortion point mapper.
`timescale 1ns / 1ps
package ldpm_pkg;

  localparam int PIX_W      = 16;
  localparam int OUT_W      = 18;
  localparam int COEF_W     = 24;
  localparam int NORM_W     = 20;
  localparam int QUO_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ONE_Q16    = 65536;
  localparam int NORM_LIMIT = 262144;
  localparam int OUT_MAX    = 131071;
  localparam int OUT_MIN    = -131072;

  localparam logic [PIX_W-1:0] FOCAL_RESET = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_PRINCIPAL = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } cfg_reg_e;

  // normalised coordinate pair, Q.16
  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic                     hit;
  } norm_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] k3;
    logic signed [COEF_W-1:0] p1;
    logic signed [COEF_W-1:0] p2;
  } coeff_t;

endpackage

/* rtl/ldpm_norm.sv */
// Normalisation: centre offset and pipelined restoring division by the focal lengths.
`timescale 1ns / 1ps
module ldpm_norm
  import ldpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pix_x,
  input  logic [PIX_W-1:0] pix_y,
  input  logic [PIX_W-1:0] fx,
  input  logic [PIX_W-1:0] fy,
  input  logic [PIX_W-1:0] cx,
  input  logic [PIX_W-1:0] cy,
  output logic             out_valid,
  input  logic             out_ready,
  output norm_item_t       out_item
);

  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic [QUO_W-1:0] dvd;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  localparam int LAST = QUO_W + 1;

  function automatic div_lane_t div_prep(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] c,
                                         logic [PIX_W-1:0] f);
    logic [PIX_W:0]   d;
    logic [PIX_W-1:0] mag;
    div_lane_t        r;
    d     = {1'b0, pix} - {1'b0, c};
    mag   = d[PIX_W] ? PIX_W'(-d) : d[PIX_W-1:0];
    r.neg = d[PIX_W];
    // quotient would need a 20th bit: |d| >= 8f
    r.ovf = {3'b000, mag} >= {f, 3'b000};
    r.rem = {3'b000, mag[PIX_W-1:3]};
    r.dvd = {mag[2:0], 16'h0000};
    r.quo = '0;
    return r;
  endfunction

  function automatic div_lane_t div_step(div_lane_t a, logic [PIX_W-1:0] f);
    logic [PIX_W:0] trial;
    div_lane_t      r;
    trial = {a.rem, a.dvd[QUO_W-1]};
    r     = a;
    r.dvd = {a.dvd[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, f}) begin
      r.rem = PIX_W'(trial - {1'b0, f});
      r.quo = {a.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[PIX_W-1:0];
      r.quo = {a.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [NORM_W-1:0] div_final(div_lane_t a, output logic hit);
    logic [QUO_W-1:0] q;
    hit = a.ovf || (a.quo > QUO_W'(NORM_LIMIT));
    q   = hit ? QUO_W'(NORM_LIMIT) : a.quo;
    return a.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  div_lane_t  lx [QUO_W+1];
  div_lane_t  ly [QUO_W+1];
  logic       v   [LAST+1];
  logic       rdy [LAST+2];
  norm_item_t fin_item;
  logic       hit_x;
  logic       hit_y;

  always_comb begin
    rdy[LAST+1] = out_ready;
    for (int k = LAST; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lx[0] <= div_prep(pix_x, cx, fx);
      ly[0] <= div_prep(pix_y, cy, fy);
    end
  end

  for (genvar g = 1; g <= QUO_W; g++) begin : g_step
    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        lx[g] <= div_step(lx[g-1], fx);
        ly[g] <= div_step(ly[g-1], fy);
      end
    end
  end

  always_comb begin
    fin_item.x   = div_final(lx[QUO_W], hit_x);
    fin_item.y   = div_final(ly[QUO_W], hit_y);
    fin_item.hit = hit_x || hit_y;
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      out_item <= fin_item;
    end
  end

  assign out_valid = v[LAST];

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.x <= NORM_W'(NORM_LIMIT) && out_item.x >= -NORM_W'(NORM_LIMIT)
                && out_item.y <= NORM_W'(NORM_LIMIT) && out_item.y >= -NORM_W'(NORM_LIMIT)))
    else $error("normalised coordinate beyond limit");

  a_norm_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted beat not held in first stage");

  a_norm_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* rtl/ldpm_poly.sv */
// Distortion polynomial, tangential terms, rescale to pixels and output saturation.
`timescale 1ns / 1ps
module ldpm_poly
  import ldpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  norm_item_t              in_item,
  input  coeff_t                  coef,
  input  logic [PIX_W-1:0]        fx,
  input  logic [PIX_W-1:0]        fy,
  input  logic [PIX_W-1:0]        cx,
  input  logic [PIX_W-1:0]        cy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_mx,
  output logic signed [OUT_W-1:0] out_my,
  output logic                    out_clip
);

  localparam int NST = 10;

  logic v   [1:NST];
  logic rdy [1:NST+1];

  always_comb begin
    rdy[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NST; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (rdy[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: squares and cross product
  logic signed [NORM_W-1:0] s1_x, s1_y;
  logic                     s1_hit;
  logic signed [21:0]       s1_x2, s1_y2, s1_xy;
  logic signed [39:0]       p_xx, p_yy, p_xy;

  always_comb begin
    p_xx = in_item.x * in_item.x;
    p_yy = in_item.y * in_item.y;
    p_xy = in_item.x * in_item.y;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_x   <= in_item.x;
      s1_y   <= in_item.y;
      s1_hit <= in_item.hit;
      s1_x2  <= p_xx[37:16];
      s1_y2  <= p_yy[37:16];
      s1_xy  <= p_xy[37:16];
    end
  end

  // stage 2: r^2 and tangential operands
  logic signed [NORM_W-1:0] s2_x, s2_y;
  logic                     s2_hit;
  logic signed [22:0]       s2_r2, s2_txy;
  logic signed [23:0]       s2_tx, s2_ty;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_x   <= s1_x;
      s2_y   <= s1_y;
      s2_hit <= s1_hit;
      s2_r2  <= 23'(s1_x2) + 23'(s1_y2);
      s2_txy <= 23'(s1_xy) <<< 1;
      s2_tx  <= 24'(s1_x2) + 24'(s1_y2) + (24'(s1_x2) <<< 1);
      s2_ty  <= 24'(s1_x2) + 24'(s1_y2) + (24'(s1_y2) <<< 1);
    end
  end

  // stage 3: r^4, k1 term, tangential products
  logic signed [NORM_W-1:0] s3_x, s3_y;
  logic                     s3_hit;
  logic signed [22:0]       s3_r2;
  logic signed [27:0]       s3_r4;
  logic signed [29:0]       s3_kr2, s3_ax, s3_ay;
  logic signed [30:0]       s3_bx, s3_by;
  logic signed [45:0]       p_r4;
  logic signed [46:0]       p_kr2, p_ax, p_ay;
  logic signed [47:0]       p_bx, p_by;

  always_comb begin
    p_r4  = s2_r2 * s2_r2;
    p_kr2 = coef.k1 * s2_r2;
    p_ax  = coef.p1 * s2_txy;
    p_ay  = coef.p2 * s2_txy;
    p_bx  = coef.p2 * s2_tx;
    p_by  = coef.p1 * s2_ty;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_x   <= s2_x;
      s3_y   <= s2_y;
      s3_hit <= s2_hit;
      s3_r2  <= s2_r2;
      s3_r4  <= p_r4[43:16];
      s3_kr2 <= p_kr2[45:16];
      s3_ax  <= p_ax[45:16];
      s3_ay  <= p_ay[45:16];
      s3_bx  <= p_bx[46:16];
      s3_by  <= p_by[46:16];
    end
  end

  // stage 4: r^6, k2 term, tangential sums
  logic signed [NORM_W-1:0] s4_x, s4_y;
  logic                     s4_hit;
  logic signed [32:0]       s4_r6;
  logic signed [34:0]       s4_kr4;
  logic signed [29:0]       s4_kr2;
  logic signed [31:0]       s4_tgx, s4_tgy;
  logic signed [50:0]       p_r6;
  logic signed [51:0]       p_kr4;

  always_comb begin
    p_r6  = s3_r4 * s3_r2;
    p_kr4 = coef.k2 * s3_r4;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_x   <= s3_x;
      s4_y   <= s3_y;
      s4_hit <= s3_hit;
      s4_r6  <= p_r6[48:16];
      s4_kr4 <= p_kr4[50:16];
      s4_kr2 <= s3_kr2;
      s4_tgx <= 32'(s3_ax) + 32'(s3_bx);
      s4_tgy <= 32'(s3_ay) + 32'(s3_by);
    end
  end

  // stage 5: k3 term and sum of the k1 and k2 terms
  logic signed [NORM_W-1:0] s5_x, s5_y;
  logic                     s5_hit;
  logic signed [39:0]       s5_kr6;
  logic signed [35:0]       s5_rsum;
  logic signed [31:0]       s5_tgx, s5_tgy;
  logic signed [56:0]       p_kr6;

  always_comb begin
    p_kr6 = coef.k3 * s4_r6;
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_x    <= s4_x;
      s5_y    <= s4_y;
      s5_hit  <= s4_hit;
      s5_kr6  <= p_kr6[55:16];
      s5_rsum <= 36'(s4_kr2) + 36'(s4_kr4);
      s5_tgx  <= s4_tgx;
      s5_tgy  <= s4_tgy;
    end
  end

  // stage 6: radial factor
  logic signed [NORM_W-1:0] s6_x, s6_y;
  logic                     s6_hit;
  logic signed [40:0]       s6_rad;
  logic signed [31:0]       s6_tgx, s6_tgy;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_x   <= s5_x;
      s6_y   <= s5_y;
      s6_hit <= s5_hit;
      s6_rad <= 41'(ONE_Q16) + 41'(s5_rsum) + 41'(s5_kr6);
      s6_tgx <= s5_tgx;
      s6_tgy <= s5_tgy;
    end
  end

  // stage 7: radial scaling
  logic                     s7_hit;
  logic signed [44:0]       s7_rx, s7_ry;
  logic signed [31:0]       s7_tgx, s7_tgy;
  logic signed [60:0]       p_rx, p_ry;

  always_comb begin
    p_rx = s6_rad * s6_x;
    p_ry = s6_rad * s6_y;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_hit <= s6_hit;
      s7_rx  <= p_rx[60:16];
      s7_ry  <= p_ry[60:16];
      s7_tgx <= s6_tgx;
      s7_tgy <= s6_tgy;
    end
  end

  // stage 8: distorted normalised coordinates
  logic               s8_hit;
  logic signed [45:0] s8_xd, s8_yd;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_hit <= s7_hit;
      s8_xd  <= 46'(s7_rx) + 46'(s7_tgx);
      s8_yd  <= 46'(s7_ry) + 46'(s7_tgy);
    end
  end

  // stage 9: back to pixels
  logic               s9_hit;
  logic signed [47:0] s9_mx, s9_my;
  logic signed [62:0] p_fx, p_fy;
  logic signed [46:0] q_fx, q_fy;

  always_comb begin
    p_fx = $signed({1'b0, fx}) * s8_xd;
    p_fy = $signed({1'b0, fy}) * s8_yd;
    q_fx = p_fx[62:16];
    q_fy = p_fy[62:16];
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_hit <= s8_hit;
      s9_mx  <= 48'(q_fx) + 48'($signed({1'b0, cx}));
      s9_my  <= 48'(q_fy) + 48'($signed({1'b0, cy}));
    end
  end

  // stage 10: saturate into the output register
  logic signed [OUT_W-1:0] sat_x, sat_y;
  logic                    hi_x, lo_x, hi_y, lo_y;

  always_comb begin
    hi_x  = s9_mx > 48'(OUT_MAX);
    lo_x  = s9_mx < 48'(OUT_MIN);
    hi_y  = s9_my > 48'(OUT_MAX);
    lo_y  = s9_my < 48'(OUT_MIN);
    sat_x = hi_x ? OUT_W'(OUT_MAX) : (lo_x ? OUT_W'(OUT_MIN) : s9_mx[OUT_W-1:0]);
    sat_y = hi_y ? OUT_W'(OUT_MAX) : (lo_y ? OUT_W'(OUT_MIN) : s9_my[OUT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      out_mx   <= sat_x;
      out_my   <= sat_y;
      out_clip <= s9_hit || hi_x || lo_x || hi_y || lo_y;
    end
  end

  a_poly_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_poly_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mx) && $stable(out_my)
                                && $stable(out_clip))
    else $error("stalled result changed");

  a_poly_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[1])
    else $error("accepted beat not held in first stage");

endmodule

/* rtl/lens_distortion_point_map.sv */
// Top level: configuration registers and the two pipeline sections.
// Pipeline: 31 register stages (21 in the divider, 10 in the polynomial section).
// Throughput: one beat per cycle while the output is not stalled, set by the fully pipelined
// divider (one quotient bit per stage) and at most one multiplier rank per stage.
// Stalls back up stage by stage; empty stages are filled while a result waits.
// Synchronous reset clears all valid bits and loads the registers with their reset values.
`timescale 1ns / 1ps
module lens_distortion_point_map
  import ldpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // pixel_x [15:0], pixel_y [31:16]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // mapped_x [17:0], mapped_y [35:18], zero [39:36]
  output logic                  m_tuser,   // clipped
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PIX_W-1:0]      focal_x, focal_y;
  logic [CFG_DATA_W-1:0] principal_point;
  coeff_t                coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x         <= FOCAL_RESET;
      focal_y         <= FOCAL_RESET;
      principal_point <= '0;
      coef            <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_FOCAL_X:   focal_x         <= cfg_data[PIX_W-1:0];
        REG_FOCAL_Y:   focal_y         <= cfg_data[PIX_W-1:0];
        REG_PRINCIPAL: principal_point <= cfg_data;
        REG_K1:        coef.k1         <= cfg_data[COEF_W-1:0];
        REG_K2:        coef.k2         <= cfg_data[COEF_W-1:0];
        REG_K3:        coef.k3         <= cfg_data[COEF_W-1:0];
        REG_P1:        coef.p1         <= cfg_data[COEF_W-1:0];
        REG_P2:        coef.p2         <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero focal length behaves as one
  logic [PIX_W-1:0] fx, fy, cx, cy;
  assign fx = (focal_x == '0) ? PIX_W'(1) : focal_x;
  assign fy = (focal_y == '0) ? PIX_W'(1) : focal_y;
  assign cx = principal_point[PIX_W-1:0];
  assign cy = principal_point[2*PIX_W-1:PIX_W];

  logic                    n_valid, n_ready;
  norm_item_t              n_item;
  logic signed [OUT_W-1:0] mx, my;
  logic                    clip;

  ldpm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .pix_x     (s_tdata[PIX_W-1:0]),
    .pix_y     (s_tdata[2*PIX_W-1:PIX_W]),
    .fx        (fx),
    .fy        (fy),
    .cx        (cx),
    .cy        (cy),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_item  (n_item)
  );

  ldpm_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_item   (n_item),
    .coef      (coef),
    .fx        (fx),
    .fy        (fy),
    .cx        (cx),
    .cy        (cy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mx    (mx),
    .out_my    (my),
    .out_clip  (clip)
  );

  assign m_tdata = {4'b0000, my, mx};
  assign m_tuser = clip;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the lens distortion point mapper.
`timescale 1ns / 1ps
module tb;
  import ldpm_pkg::*;

  typedef struct {
    logic [17:0] mx;
    logic [17:0] my;
    logic        clip;
  } mapped_t;

  typedef struct {
    logic        is_cfg;
    cfg_reg_e    idx;
    logic [31:0] data;
    logic [31:0] pix;
  } pend_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [39:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lens_distortion_point_map DUT (.*);

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [15:0] fx_r = FOCAL_RESET, fy_r = FOCAL_RESET, cx_r = '0, cy_r = '0;
  longint k1_r = 0, k2_r = 0, k3_r = 0, p1_r = 0, p2_r = 0;

  pend_t   beat_q[$];
  mapped_t mapped_q[$];
  int      send_idle = 23, recv_idle = 63;
  int      hold_cnt = 0;
  bit      failed = 0;
  bit      feed_done = 0;
  longint  cycles = 0;

  function automatic longint floor_shift(longint v);
    return v >>> 16;
  endfunction

  function automatic longint qm(longint a, longint b);
    return floor_shift(a * b);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi, ref bit hit);
    if (v > hi) begin hit = 1; return hi; end
    if (v < lo) begin hit = 1; return lo; end
    return v;
  endfunction

  function automatic void store_reg(cfg_reg_e idx, logic [31:0] d);
    case (idx)
      REG_FOCAL_X: fx_r = d[15:0];
      REG_FOCAL_Y: fy_r = d[15:0];
      REG_PRINCIPAL: begin cx_r = d[15:0]; cy_r = d[31:16]; end
      REG_K1: k1_r = longint'(signed'(d[23:0]));
      REG_K2: k2_r = longint'(signed'(d[23:0]));
      REG_K3: k3_r = longint'(signed'(d[23:0]));
      REG_P1: p1_r = longint'(signed'(d[23:0]));
      REG_P2: p2_r = longint'(signed'(d[23:0]));
      default: ;
    endcase
  endfunction

  function automatic mapped_t distort_point(logic [31:0] pix);
    mapped_t r;
    bit hit;
    longint fx, fy, x, y, x2, y2, xy, r2, r4, r6, rad, xd, yd, mx, my;
    hit = 0;
    fx = (fx_r == 0) ? 1 : fx_r;
    fy = (fy_r == 0) ? 1 : fy_r;
    // SV division truncates toward zero
    x = ((longint'(pix[15:0]) - longint'(cx_r)) * 65536) / fx;
    y = ((longint'(pix[31:16]) - longint'(cy_r)) * 65536) / fy;
    x = sat(x, -NORM_LIMIT, NORM_LIMIT, hit);
    y = sat(y, -NORM_LIMIT, NORM_LIMIT, hit);
    x2 = qm(x, x); y2 = qm(y, y); xy = qm(x, y);
    r2 = x2 + y2; r4 = qm(r2, r2); r6 = qm(r4, r2);
    rad = ONE_Q16 + qm(k1_r, r2) + qm(k2_r, r4) + qm(k3_r, r6);
    xd = qm(rad, x) + qm(p1_r, 2 * xy) + qm(p2_r, r2 + 2 * x2);
    yd = qm(rad, y) + qm(p2_r, 2 * xy) + qm(p1_r, r2 + 2 * y2);
    mx = sat(qm(fx, xd) + cx_r, OUT_MIN, OUT_MAX, hit);
    my = sat(qm(fy, yd) + cy_r, OUT_MIN, OUT_MAX, hit);
    r.mx = mx[17:0]; r.my = my[17:0]; r.clip = hit;
    return r;
  endfunction

  function automatic void push_pix(logic [15:0] px, logic [15:0] py);
    pend_t p;
    p.is_cfg = 0; p.idx = REG_FOCAL_X; p.data = '0; p.pix = {py, px};
    beat_q = {beat_q, p};
  endfunction

  function automatic void push_cfg(cfg_reg_e idx, logic [31:0] d);
    pend_t p;
    p.is_cfg = 1; p.idx = idx; p.data = d; p.pix = '0;
    beat_q = {beat_q, p};
  endfunction

  function automatic logic [31:0] rand_coef(int sc);
    case (sc)
      0: return 32'h7FFFFF;
      1: return 32'h800000;
      2: return 32'd0;
      3: return $urandom;
      default: return $urandom_range(0, 8191) - 4096;
    endcase
  endfunction

  // driver: a config entry at the queue head waits until the pipe has drained
  always @(posedge clk) begin
    logic we_next;
    we_next = 0;
    if (rst) begin
      s_tvalid <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (beat_q.size() > 0 && beat_q[0].is_cfg) begin
        if (mapped_q.size() == 0 && !m_tvalid && hold_cnt == 0) begin
          hold_cnt <= 1;
          s_tvalid <= 0;
        end else if (hold_cnt > 0 && hold_cnt < 40) begin
          hold_cnt <= hold_cnt + 1;
          s_tvalid <= 0;
        end else if (hold_cnt >= 40) begin
          we_next = 1;
          cfg_index <= beat_q[0].idx;
          cfg_data <= beat_q[0].data;
          store_reg(beat_q[0].idx, beat_q[0].data);
          void'(beat_q.pop_front());
          hold_cnt <= 0;
          s_tvalid <= 0;
        end else begin
          s_tvalid <= 0;
        end
      end else if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_tvalid <= 1;
        s_tdata <= beat_q[0].pix;
        mapped_q = {mapped_q, distort_point(beat_q[0].pix)};
        void'(beat_q.pop_front());
      end else begin
        s_tvalid <= 0;
      end
    end
    cfg_we <= we_next;
  end

  // long receiver hold-off, timed in its own process
  event stall_go;
  bit   stall_on = 0;
  always begin
    @(stall_go);
    stall_on <= 1;
    repeat (1500) @(posedge clk);
    stall_on <= 0;
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    mapped_t e;
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (mapped_q.size() == 0) begin
          $error("unexpected beat %h", m_tdata);
          failed = 1;
        end else begin
          e = mapped_q.pop_front();
          if (m_tdata[17:0] !== e.mx) begin
            $error("mapped_x exp %h got %h", e.mx, m_tdata[17:0]); failed = 1;
          end
          if (m_tdata[35:18] !== e.my) begin
            $error("mapped_y exp %h got %h", e.my, m_tdata[35:18]); failed = 1;
          end
          if (m_tuser !== e.clip) begin
            $error("clipped exp %b got %b", e.clip, m_tuser); failed = 1;
          end
        end
      end
      if (stall_on) begin
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed: reset settings, field extremes
    push_pix(0, 0); push_pix(16'hFFFF, 16'hFFFF); push_pix(16'hFFFF, 0);
    push_pix(0, 16'hFFFF); push_pix(16'h5555, 16'hAAAA);
    // centred, distortion, zero focal lengths, far-from-centre clipping
    push_cfg(REG_PRINCIPAL, {16'd8000, 16'd8000});
    push_cfg(REG_K1, 32'h7FFFFF); push_cfg(REG_K2, 32'h800000);
    push_cfg(REG_K3, 32'h001000); push_cfg(REG_P1, 32'h800000);
    push_cfg(REG_P2, 32'h7FFFFF);
    push_pix(8000, 8000); push_pix(0, 16'hFFFF); push_pix(8100, 7900);
    push_cfg(REG_FOCAL_X, 0); push_cfg(REG_FOCAL_Y, 32'hFFFF);
    push_pix(8001, 7999); push_pix(0, 0); push_pix(16'hFFFF, 16'hFFFF);
    push_cfg(REG_FOCAL_X, 1); push_cfg(REG_FOCAL_Y, 0);
    push_pix(7999, 8001); push_pix(16'h8000, 16'h7FFF);
    // random phases; each with its own settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        wait (beat_q.size() == 0 && mapped_q.size() == 0);
        send_idle = 63; recv_idle = 23;
        -> stall_go;
      end
      if (ph == 8) begin
        wait (beat_q.size() == 0 && mapped_q.size() == 0);
        send_idle = 0; recv_idle = 0;
      end
      push_cfg(REG_FOCAL_X, (ph % 3 == 0) ? $urandom_range(1, 65535)
                                           : $urandom_range(2000, 30000));
      push_cfg(REG_FOCAL_Y, (ph == 5) ? 32'hFFFF : $urandom_range(2000, 30000));
      push_cfg(REG_PRINCIPAL, (ph == 2) ? 32'hFFFFFFFF : $urandom);
      push_cfg(REG_K1, rand_coef(ph % 5)); push_cfg(REG_K2, rand_coef((ph + 1) % 5));
      push_cfg(REG_K3, rand_coef((ph + 2) % 5)); push_cfg(REG_P1, rand_coef((ph + 3) % 5));
      push_cfg(REG_P2, rand_coef((ph + 4) % 5));
      n = 108;
      for (int i = 0; i < n; i++) push_pix($urandom, $urandom);
    end
    feed_done = 1;
  end

  initial begin
    wait (feed_done && beat_q.size() == 0 && mapped_q.size() == 0);
    repeat (60) @(posedge clk);
    if (!failed) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    wait (cycles == 400000);
    $display("tb: FAIL");
    $finish;
  end
endmodule

/* sim.f */
rtl/ldpm_pkg.sv
rtl/ldpm_norm.sv
rtl/ldpm_poly.sv
rtl/lens_distortion_point_map.sv
sim/tb.sv
